FILE: rtl/justify_gap_distributor_unit_defines.svh
// assertion macros used by the justify gap distributor controller
`ifndef JUSTIFY_GAP_DISTRIBUTOR_UNIT_DEFINES_SVH
`define JUSTIFY_GAP_DISTRIBUTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define JGD_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define JGD_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define JGD_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define JGD_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)
`endif

`endif

FILE: rtl/jgd_pkg.sv
// shared types and constants of the justify gap distributor
package jgd_pkg;

  localparam int ADV_W      = 24;
  localparam int GAP_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_STEPS  = ADV_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int IN_USER_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STRETCH_TOTAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_COUNT     = 1'd1;

  // input tuser bit positions
  localparam int TU_LINE_START    = 0;
  localparam int TU_CLUSTER_VALID = 1;
  localparam int TU_IS_SPACE      = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_load;
    logic out_load;
    logic out_from_input;
  } cmd_t;

  typedef struct packed {
    logic line_start;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/jgd_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
module jgd_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [jgd_pkg::ADV_W-1:0] dividend,
  input  logic [jgd_pkg::GAP_W-1:0] divisor,
  output logic [jgd_pkg::ADV_W-1:0] quotient,
  output logic [jgd_pkg::GAP_W-1:0] remainder,
  output logic                      done
);
  import jgd_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [ADV_W-1:0]     dq;
  logic [GAP_W-1:0]     rem;
  logic [GAP_W-1:0]     dvs;
  logic [GAP_W:0]       trial;
  logic                 qbit;

  assign trial = {rem, dq[ADV_W-1]};
  assign qbit  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[ADV_W-2:0], qbit};
      // remainder stays below the divisor, so the low bits hold it
      rem <= qbit ? GAP_W'(trial - {1'b0, dvs}) : trial[GAP_W-1:0];
    end
  end

  assign quotient  = dq;
  assign remainder = rem;

endmodule

FILE: rtl/jgd_ctrl.sv
// controller state machine of the justify gap distributor
`include "justify_gap_distributor_unit_defines.svh"

module jgd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  jgd_pkg::status_t status,
  output jgd_pkg::cmd_t    cmd
);
  import jgd_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && status.line_start) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = status.out_free;
        if (accept) begin
          if (status.line_start) begin
            cmd.capture   = 1'b1;
            cmd.div_start = 1'b1;
          end else begin
            // plain glyph goes straight from the input to the output register
            cmd.out_load       = 1'b1;
            cmd.out_from_input = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_load = status.div_done;
      end
      ST_APPLY: begin
        cmd.out_load = status.out_free;
      end
      default: ;
    endcase
  end

  `JGD_ASSERT_NXT(a_div_start_enters_div, clk, rst, cmd.div_start, state == ST_DIV, "div start without div state")
  `JGD_ASSERT_IMP(a_done_only_in_div, clk, rst, status.div_done, state == ST_DIV, "divider done outside div state")
  `JGD_ASSERT_IMP(a_no_output_overwrite, clk, rst, cmd.out_load, status.out_free, "output register overwritten")
  `JGD_ASSERT_NXT(a_load_then_apply, clk, rst, cmd.div_load, state == ST_APPLY, "share load without apply")

endmodule

FILE: rtl/jgd_datapath.sv
// datapath: config registers, divider, line state, adjust and output register
module jgd_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [jgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jgd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [jgd_pkg::ADV_W-1:0]      s_tdata,
  input  logic [jgd_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [jgd_pkg::ADV_W-1:0]      m_tdata,
  output logic                           m_tuser,
  input  jgd_pkg::cmd_t                  cmd,
  output jgd_pkg::status_t               status
);
  import jgd_pkg::*;

  logic [ADV_W-1:0] stretch_total;
  logic [GAP_W-1:0] gap_count;

  logic [ADV_W-1:0] share_per_gap;
  logic [GAP_W-1:0] remainder_left;
  logic             remainder_sign;

  logic             cap_valid;
  logic             cap_space;
  logic [ADV_W-1:0] cap_adv;

  logic [ADV_W-1:0] adv_out;
  logic             stretched_out;
  logic             out_valid;

  logic             total_neg;
  logic [ADV_W-1:0] total_mag;
  logic             no_stretch;
  logic [ADV_W-1:0] div_q;
  logic [GAP_W-1:0] div_r;
  logic             div_done;

  logic             src_valid;
  logic             src_space;
  logic [ADV_W-1:0] src_adv;
  logic             take;
  logic             rem_nz;
  logic [ADV_W:0]   unit;
  logic [ADV_W:0]   delta;
  logic [ADV_W+1:0] sum;
  logic [ADV_W-1:0] adv_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      stretch_total <= '0;
      gap_count     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRETCH_TOTAL: stretch_total <= cfg_data[ADV_W-1:0];
        REG_GAP_COUNT:     gap_count     <= cfg_data[GAP_W-1:0];
      endcase
    end
  end

  assign total_neg  = stretch_total[ADV_W-1];
  assign total_mag  = total_neg ? ADV_W'(-stretch_total) : stretch_total;
  assign no_stretch = (gap_count == '0) || (stretch_total == '0);

  jgd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (total_mag),
    .divisor   (gap_count),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_valid <= s_tuser[TU_CLUSTER_VALID];
      cap_space <= s_tuser[TU_IS_SPACE];
      cap_adv   <= s_tdata;
    end
  end

  assign src_valid = cmd.out_from_input ? s_tuser[TU_CLUSTER_VALID] : cap_valid;
  assign src_space = cmd.out_from_input ? s_tuser[TU_IS_SPACE] : cap_space;
  assign src_adv   = cmd.out_from_input ? s_tdata : cap_adv;

  assign take   = src_valid && src_space;
  assign rem_nz = (remainder_left != '0);
  assign unit   = !rem_nz ? '0 : (remainder_sign ? '1 : (ADV_W+1)'(1));
  assign delta  = take ? ({share_per_gap[ADV_W-1], share_per_gap} + unit) : '0;
  assign sum    = {{2{src_adv[ADV_W-1]}}, src_adv} + {delta[ADV_W], delta};

  // saturate when the top three bits disagree
  always_comb begin
    if (sum[ADV_W+1:ADV_W-1] == 3'b000 || sum[ADV_W+1:ADV_W-1] == 3'b111) begin
      adv_sat = sum[ADV_W-1:0];
    end else if (sum[ADV_W+1]) begin
      adv_sat = {1'b1, {(ADV_W-1){1'b0}}};
    end else begin
      adv_sat = {1'b0, {(ADV_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      share_per_gap  <= '0;
      remainder_left <= '0;
      remainder_sign <= 1'b0;
    end else if (cmd.div_load) begin
      share_per_gap  <= no_stretch ? '0 : (total_neg ? ADV_W'(-div_q) : div_q);
      remainder_left <= no_stretch ? '0 : div_r;
      remainder_sign <= no_stretch ? 1'b0 : total_neg;
    end else if (cmd.out_load && take && rem_nz) begin
      remainder_left <= remainder_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      adv_out       <= adv_sat;
      stretched_out <= (delta != '0);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = adv_out;
  assign m_tuser  = stretched_out;

  assign status.line_start = s_tuser[TU_LINE_START];
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid || m_tready;

endmodule

FILE: rtl/justify_gap_distributor_unit.sv
// top level: spreads a justification stretch over the whitespace glyphs of a line
// plain glyph: registered result in the cycle after the input transaction, one per cycle unless the output stalls
// line-start glyph: captured, then the 24-step bit-serial divider of stretch_total by
//   gap_count runs, the share is loaded and the result registered; no input meanwhile
// reset (rst, synchronous, active high) clears config registers, share and remainder
// input stalls while a finished result waits in the output register
module justify_gap_distributor_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [jgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jgd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [jgd_pkg::ADV_W-1:0]      s_tdata,  // advance_in
  input  logic [jgd_pkg::IN_USER_W-1:0]  s_tuser,  // line_start, cluster_valid, is_space
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [jgd_pkg::ADV_W-1:0]      m_tdata,  // advance_out
  output logic                           m_tuser   // stretched
);
  import jgd_pkg::*;

  cmd_t    cmd;
  status_t status;

  jgd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  jgd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
